### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects a clock named clk and,
// where reset gates the check, a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int POS_W   = 5;
  localparam int BYTES_W = 3;
  localparam logic [BYTES_W-1:0] MAX_BYTES = 3'd4;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PUSH_FRONT = 3'd1,
    EV_PUSH_BACK  = 3'd2,
    EV_POP_FRONT  = 3'd3,
    EV_POP_BACK   = 3'd4,
    EV_CLEAR      = 3'd5
  } event_t;

endpackage

`default_nettype wire

### rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/double_ended_ring_queue.sv
// Ring deque held in one synchronous RAM, with front, back and count in flops.
// The response to an accepted command is registered and shows in the next cycle.
// Throughput: one command per cycle while the response is not stalled; the RAM
// read port is registered and its data shows with the registered response fields.
// Reset (synchronous, active high) empties the deque and drops any response;
// RAM contents are left as they are and are only read inside the live size.
`default_nettype none

module double_ended_ring_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  output logic                              cmd_stall,
  input  wire logic [2:0]                   mode,
  input  wire logic [DATA_WIDTH-1:0]        data_word,
  input  wire logic [BYTES_W-1:0]           byte_count,
  input  wire logic signed [POS_W-1:0]      position,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [$clog2(DEPTH+1)-1:0]        size_after,
  output logic [2:0]                        event_code,
  output logic                              evicted_on_full,
  output logic                              read_valid,
  output logic [DATA_WIDTH-1:0]             read_word,
  output logic [BYTES_W-1:0]                read_count
);

  `include "assert_macros.svh"

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int SW = PW + 1;
  localparam int MW = DATA_WIDTH + BYTES_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  logic [PW-1:0] front, front_next;
  logic [PW-1:0] back, back_next;
  logic [CW-1:0] count, count_next;

  logic          accept;
  logic          full;
  logic [BYTES_W-1:0] bytes_clamp;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [MW-1:0] rdata;

  logic signed [LW-1:0] pos_ext;
  logic signed [LW-1:0] logical;
  logic                 in_range;
  logic [SW-1:0]        phys_sum;
  logic [PW-1:0]        phys;

  event_t        ev;
  logic          evict;
  logic [PW-1:0] back_room;

  event_t        ev_q;
  logic          evict_q;
  logic          hit_q;
  logic [CW-1:0] size_q;
  logic [SW-1:0] chk_sum;

  // A new command may enter whenever the response register is free or drains.
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (count == CW'(DEPTH));
  assign bytes_clamp = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;

  // Logical index: negative positions count back from the size.
  assign pos_ext  = LW'(position);
  assign logical  = position[POS_W-1] ? (pos_ext + $signed(LW'(count)))
                                      : pos_ext;
  assign in_range = !logical[LW-1] && (logical < $signed(LW'(count)));

  // Entry i sits at front - 1 - i around the ring.
  assign phys_sum = {1'b0, front} + SW'(DEPTH - 1) - {1'b0, logical[PW-1:0]};
  assign phys     = (phys_sum >= SW'(DEPTH)) ? PW'(phys_sum - SW'(DEPTH))
                                             : phys_sum[PW-1:0];

  // A push into a full ring first drops the back entry.
  assign back_room = full ? ptr_inc(back) : back;

  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    ev         = EV_NONE;
    evict      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = front;
    rd_en      = 1'b0;
    rd_addr    = phys;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (bytes_clamp != '0) begin
          evict      = full;
          wr_en      = 1'b1;
          wr_addr    = front;
          front_next = ptr_inc(front);
          back_next  = back_room;
          count_next = full ? count : count + 1'b1;
          ev         = EV_PUSH_FRONT;
        end
      end
      MODE_PUSH_BACK: begin
        if (bytes_clamp != '0) begin
          evict      = full;
          wr_en      = 1'b1;
          wr_addr    = ptr_dec(back_room);
          back_next  = ptr_dec(back_room);
          count_next = full ? count : count + 1'b1;
          ev         = EV_PUSH_BACK;
        end
      end
      MODE_POP_FRONT: begin
        if (count != '0) begin
          front_next = ptr_dec(front);
          count_next = count - 1'b1;
          ev         = EV_POP_FRONT;
        end
      end
      MODE_POP_BACK: begin
        if (count != '0) begin
          back_next  = ptr_inc(back);
          count_next = count - 1'b1;
          ev         = EV_POP_BACK;
        end
      end
      MODE_READ: begin
        rd_en = in_range;
      end
      MODE_CLEAR: begin
        front_next = '0;
        back_next  = '0;
        count_next = '0;
        ev         = (count != '0) ? EV_CLEAR : EV_NONE;
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wr_addr),
    .wdata ({bytes_clamp, data_word}),
    .re    (accept && rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        front <= front_next;
        back  <= back_next;
        count <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      size_q  <= count_next;
      ev_q    <= ev;
      evict_q <= evict;
      hit_q   <= (mode == MODE_READ) && in_range;
    end
  end

  assign size_after      = size_q;
  assign event_code      = ev_q;
  assign evicted_on_full = evict_q;
  assign read_valid      = hit_q;
  assign read_word       = hit_q ? rdata[DATA_WIDTH-1:0] : '0;
  assign read_count      = hit_q ? rdata[MW-1:DATA_WIDTH] : '0;

  // The back pointer plus the count lands on the front pointer around the ring.
  assign chk_sum = {1'b0, back} + SW'(count);

  `ASSERT_CLK(a_count_bound, count <= CW'(DEPTH), "entry count above capacity")
  `ASSERT_CLK(a_ring_consistent,
    ((chk_sum >= SW'(DEPTH)) ? PW'(chk_sum - SW'(DEPTH)) : chk_sum[PW-1:0]) == front,
    "front, back and count disagree")
  `ASSERT_CLK(a_evict_full, rsp_valid && evicted_on_full |-> size_after == CW'(DEPTH),
    "eviction reported below capacity")
  `ASSERT_CLK(a_reset_empty, $past(rst) |-> (count == '0 && !rsp_valid),
    "deque not empty after reset")

endmodule

`default_nettype wire
